/* rtl/core/wesd_pkg.sv */
`timescale 1ns / 1ps

package wesd_pkg;

  // Request kinds carried on the input word.
  localparam logic [2:0] REQ_PULSE    = 3'd0;
  localparam logic [2:0] REQ_OVERFLOW = 3'd1;
  localparam logic [2:0] REQ_TARGET   = 3'd2;
  localparam logic [2:0] REQ_STEER    = 3'd3;
  localparam logic [2:0] REQ_START    = 3'd4;
  localparam logic [2:0] REQ_STOP     = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STEP_CM      = 2'd0;
  localparam logic [1:0] CFG_TICKS_PER_MS = 2'd1;
  localparam logic [1:0] CFG_STEER_THRESH = 2'd2;

  // Register reset values.
  localparam logic [7:0]  STEP_CM_RESET      = 8'd2;
  localparam logic [15:0] TICKS_PER_MS_RESET = 16'd500;
  localparam logic [7:0]  STEER_THRESH_RESET = 8'd90;

  // Samples per averaging window.
  localparam int AVG_SAMPLES_DEF = 7;

  // Speed scale: step in cm over a period in ms gives mm/s.
  localparam logic [23:0] SPEED_SCALE = 24'd10000;
  localparam logic [15:0] U16_MAX     = 16'hFFFF;

  // Shared divider widths.
  localparam int DIVIDEND_W = 24;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  typedef struct packed {
    logic [7:0]  step_cm;
    logic [15:0] ticks_per_ms;
    logic [7:0]  steer_threshold;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        speed_ready;
    logic        speed_channel;
    logic [15:0] avg_speed;
    logic        reached;
    logic        dist_ready;
    logic [15:0] dist_one;
    logic [15:0] dist_two;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MS_WAIT,
    ST_SPD_WAIT,
    ST_ACCUM,
    ST_AVG_WAIT,
    ST_COUNT,
    ST_TGT_WAIT,
    ST_MUL_ONE,
    ST_MUL_TWO,
    ST_DONE
  } state_t;

  // Clamp a wide unsigned value to 16 bits.
  function automatic logic [15:0] sat16(input logic [23:0] v);
    sat16 = (v > {8'd0, U16_MAX}) ? U16_MAX : v[15:0];
  endfunction

  // Increment that sticks at the 16-bit maximum.
  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == U16_MAX) ? v : v + 16'd1;
  endfunction

endpackage

/* rtl/core/wesd_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. A start loads the operands
// and the quotient is presented with a one-cycle done pulse after the last
// iteration.
module wesd_div (
  input  logic                clk,
  input  logic                rst,
  input  wesd_pkg::div_req_t  req,
  output wesd_pkg::div_rsp_t  rsp
);

  localparam int DW = wesd_pkg::DIVIDEND_W;
  localparam int VW = wesd_pkg::DIVISOR_W;
  localparam int CW = wesd_pkg::DIV_CNT_W;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [VW-1:0] dvs;

  logic [VW:0]   rem_shift;
  logic [VW:0]   rem_sub;
  logic          ge;

  // One trial subtraction per cycle.
  always_comb begin
    rem_shift = {rem, quo[DW-1]};
    ge        = rem_shift >= {1'b0, dvs};
    rem_sub   = rem_shift - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? rem_sub[VW-1:0] : rem_shift[VW-1:0];
        quo <= {quo[DW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* rtl/core/wesd_core.sv */
`timescale 1ns / 1ps

// Event sequencer: holds the wheel state, steers the shared divider and a
// small multiplier, and keeps the finished result in an output register.
module wesd_core #(
  parameter int AVG_SAMPLES = wesd_pkg::AVG_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  wesd_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_req,
  input  logic              in_ch,
  input  logic [15:0]       in_gap,
  input  logic [7:0]        in_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output wesd_pkg::result_t out_result
);

  wesd_pkg::state_t state, state_next;

  // Per-wheel and global state.
  logic [1:0]  armed;
  logic [19:0] speed_sum [2];
  logic [3:0]  sample_count [2];
  logic        counting_on;
  logic [15:0] trip_pulses [2];
  logic [7:0]  target_pulses;
  logic [15:0] target_seen [2];
  logic        target_active;
  logic        steer_wheel_one;

  // Item being worked on and working registers.
  logic [2:0]  req_r;
  logic        ch_r;
  logic [15:0] gap_r;
  logic [7:0]  cmd_r;
  logic [15:0] speed_r;
  logic [23:0] prod_r;
  wesd_pkg::result_t res_r;

  wesd_pkg::div_req_t div_req;
  wesd_pkg::div_rsp_t div_rsp;

  logic [15:0] tpm_eff;
  logic [15:0] ms;
  logic [19:0] sum_new;
  logic [3:0]  cnt_new;
  logic        win_full;
  logic        is_pulse;
  logic        wsel;
  logic [15:0] seen_new;
  logic [15:0] seen_steered;
  logic        reach_now;
  logic        load_out;

  wesd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Shared derived values.
  always_comb begin
    tpm_eff      = (cfg.ticks_per_ms == 16'd0) ? 16'd1 : cfg.ticks_per_ms;
    ms           = div_rsp.quotient[15:0];
    sum_new      = speed_sum[ch_r] + {4'd0, speed_r};
    cnt_new      = sample_count[ch_r] + 4'd1;
    win_full     = cnt_new == 4'(AVG_SAMPLES);
    is_pulse     = req_r == wesd_pkg::REQ_PULSE;
    wsel         = ~steer_wheel_one;
    seen_new     = wesd_pkg::sat_inc16(target_seen[ch_r]);
    seen_steered = (wsel == ch_r) ? seen_new : target_seen[wsel];
    reach_now    = seen_steered > {8'd0, target_pulses};
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      wesd_pkg::ST_IDLE: begin
        if (in_valid) state_next = wesd_pkg::ST_DISPATCH;
      end
      wesd_pkg::ST_DISPATCH: begin
        case (req_r)
          wesd_pkg::REQ_PULSE:
            state_next = armed[ch_r] ? wesd_pkg::ST_MS_WAIT : wesd_pkg::ST_DONE;
          wesd_pkg::REQ_OVERFLOW: state_next = wesd_pkg::ST_ACCUM;
          wesd_pkg::REQ_TARGET:
            state_next = (cfg.step_cm == 8'd0) ? wesd_pkg::ST_DONE : wesd_pkg::ST_TGT_WAIT;
          wesd_pkg::REQ_STOP: state_next = wesd_pkg::ST_MUL_ONE;
          default: state_next = wesd_pkg::ST_DONE;
        endcase
      end
      wesd_pkg::ST_MS_WAIT: begin
        if (div_rsp.done)
          state_next = (ms == 16'd0) ? wesd_pkg::ST_ACCUM : wesd_pkg::ST_SPD_WAIT;
      end
      wesd_pkg::ST_SPD_WAIT: begin
        if (div_rsp.done) state_next = wesd_pkg::ST_ACCUM;
      end
      wesd_pkg::ST_ACCUM: begin
        if (win_full)      state_next = wesd_pkg::ST_AVG_WAIT;
        else if (is_pulse) state_next = wesd_pkg::ST_COUNT;
        else               state_next = wesd_pkg::ST_DONE;
      end
      wesd_pkg::ST_AVG_WAIT: begin
        if (div_rsp.done)
          state_next = is_pulse ? wesd_pkg::ST_COUNT : wesd_pkg::ST_DONE;
      end
      wesd_pkg::ST_COUNT:   state_next = wesd_pkg::ST_DONE;
      wesd_pkg::ST_TGT_WAIT: begin
        if (div_rsp.done) state_next = wesd_pkg::ST_DONE;
      end
      wesd_pkg::ST_MUL_ONE: state_next = wesd_pkg::ST_MUL_TWO;
      wesd_pkg::ST_MUL_TWO: state_next = wesd_pkg::ST_DONE;
      wesd_pkg::ST_DONE: begin
        if (!out_valid || out_ready) state_next = wesd_pkg::ST_IDLE;
      end
      default: state_next = wesd_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and divider requests.
  always_comb begin
    in_ready         = state == wesd_pkg::ST_IDLE;
    load_out         = (state == wesd_pkg::ST_DONE) && (!out_valid || out_ready);
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state)
      wesd_pkg::ST_DISPATCH: begin
        if (is_pulse && armed[ch_r]) begin
          div_req.start    = 1'b1;
          div_req.dividend = {8'd0, gap_r};
          div_req.divisor  = tpm_eff;
        end else if (req_r == wesd_pkg::REQ_TARGET && cfg.step_cm != 8'd0) begin
          div_req.start    = 1'b1;
          div_req.dividend = {16'd0, cmd_r};
          div_req.divisor  = {8'd0, cfg.step_cm};
        end
      end
      wesd_pkg::ST_MS_WAIT: begin
        if (div_rsp.done && ms != 16'd0) begin
          div_req.start    = 1'b1;
          div_req.dividend = 24'({16'd0, cfg.step_cm} * wesd_pkg::SPEED_SCALE);
          div_req.divisor  = ms;
        end
      end
      wesd_pkg::ST_ACCUM: begin
        if (win_full) begin
          div_req.start    = 1'b1;
          div_req.dividend = {4'd0, sum_new};
          div_req.divisor  = 16'(AVG_SAMPLES);
        end
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= wesd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Datapath and wheel state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed           <= '0;
      speed_sum[0]    <= '0;
      speed_sum[1]    <= '0;
      sample_count[0] <= '0;
      sample_count[1] <= '0;
      counting_on     <= 1'b0;
      trip_pulses[0]  <= '0;
      trip_pulses[1]  <= '0;
      target_pulses   <= '0;
      target_seen[0]  <= '0;
      target_seen[1]  <= '0;
      target_active   <= 1'b0;
      steer_wheel_one <= 1'b0;
    end else begin
      case (state)
        wesd_pkg::ST_IDLE: begin
          if (in_valid) begin
            req_r <= in_req;
            ch_r  <= in_ch;
            gap_r <= in_gap;
            cmd_r <= in_cmd;
            res_r <= '0;
          end
        end
        wesd_pkg::ST_DISPATCH: begin
          case (req_r)
            wesd_pkg::REQ_PULSE: begin
              if (!armed[ch_r]) armed[ch_r] <= 1'b1;
            end
            wesd_pkg::REQ_OVERFLOW: speed_r <= 16'd0;
            wesd_pkg::REQ_TARGET: begin
              if (cfg.step_cm == 8'd0) begin
                target_pulses  <= 8'hFF;
                target_seen[0] <= '0;
                target_seen[1] <= '0;
                target_active  <= 1'b1;
              end
            end
            wesd_pkg::REQ_STEER: steer_wheel_one <= cmd_r >= cfg.steer_threshold;
            wesd_pkg::REQ_START: begin
              trip_pulses[0] <= '0;
              trip_pulses[1] <= '0;
              counting_on    <= 1'b1;
            end
            wesd_pkg::REQ_STOP: prod_r <= 24'(cfg.step_cm) * 24'(trip_pulses[0]);
            default: begin
              prod_r <= prod_r;
            end
          endcase
        end
        wesd_pkg::ST_MS_WAIT: begin
          // A period below one millisecond reads as full speed.
          if (div_rsp.done && ms == 16'd0) speed_r <= wesd_pkg::U16_MAX;
        end
        wesd_pkg::ST_SPD_WAIT: begin
          if (div_rsp.done) speed_r <= wesd_pkg::sat16(div_rsp.quotient);
        end
        wesd_pkg::ST_ACCUM: begin
          if (win_full) begin
            speed_sum[ch_r]    <= '0;
            sample_count[ch_r] <= '0;
          end else begin
            speed_sum[ch_r]    <= sum_new;
            sample_count[ch_r] <= cnt_new;
          end
        end
        wesd_pkg::ST_AVG_WAIT: begin
          if (div_rsp.done) begin
            res_r.speed_ready   <= 1'b1;
            res_r.speed_channel <= ch_r;
            res_r.avg_speed     <= wesd_pkg::sat16(div_rsp.quotient);
          end
        end
        wesd_pkg::ST_COUNT: begin
          if (counting_on) trip_pulses[ch_r] <= wesd_pkg::sat_inc16(trip_pulses[ch_r]);
          if (target_active) begin
            target_seen[ch_r] <= seen_new;
            res_r.reached     <= reach_now;
          end
        end
        wesd_pkg::ST_TGT_WAIT: begin
          if (div_rsp.done) begin
            target_pulses  <= div_rsp.quotient[7:0];
            target_seen[0] <= '0;
            target_seen[1] <= '0;
            target_active  <= 1'b1;
          end
        end
        wesd_pkg::ST_MUL_ONE: begin
          res_r.dist_one <= wesd_pkg::sat16(prod_r);
          prod_r         <= 24'(cfg.step_cm) * 24'(trip_pulses[1]);
        end
        wesd_pkg::ST_MUL_TWO: begin
          res_r.dist_two   <= wesd_pkg::sat16(prod_r);
          res_r.dist_ready <= 1'b1;
          counting_on      <= 1'b0;
        end
        default: begin
          counting_on <= counting_on;
        end
      endcase
    end
  end

  // Output register: a finished word waits here until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid  <= 1'b1;
      out_result <= res_r;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/wheel_encoder_speed_distance.sv */
`timescale 1ns / 1ps

// Two-channel wheel encoder unit. Each input word is one event (pulse with
// captured ticks, timer overflow, distance target, steering angle, count
// start or count stop) and gives exactly one output word. All divisions go
// through one shared restoring divider of 24 iterations, so the time from one
// accepted word to the next depends on the event: an armed pulse runs the
// period and speed divisions, and the averaging division as well when it
// completes an averaging window; an armed pulse with a period below one
// millisecond skips the speed division; an overflow needs a division only
// with a full window; a distance target needs one unless the step is zero;
// count stop uses the multiplier; and the other events need no division.
// Add to that any time the previous output word still waits to be taken.
// One word is worked on at a time and s_axis_tready is high only while the
// unit is idle; the next word may be accepted while the previous result still
// sits in the output register.
// Configuration writes are always accepted and must only be issued while the
// unit is idle.
module wheel_encoder_speed_distance #(
  parameter int AVG_SAMPLES = wesd_pkg::AVG_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Event input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // gap_ticks[15:0], cmd_value[23:16]
  input  logic [3:0]  s_axis_tuser,  // req_type[2:0], channel[3]
  // Result output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // avg_speed[15:0], dist_one[31:16], dist_two[47:32]
  output logic [3:0]  m_axis_tuser   // speed_ready[0], speed_channel[1], reached[2],
                                     // dist_ready[3]
);

  wesd_pkg::cfg_t    cfg;
  wesd_pkg::result_t res;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_cm         <= wesd_pkg::STEP_CM_RESET;
      cfg.ticks_per_ms    <= wesd_pkg::TICKS_PER_MS_RESET;
      cfg.steer_threshold <= wesd_pkg::STEER_THRESH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        wesd_pkg::CFG_STEP_CM:      cfg.step_cm         <= cfg_data[7:0];
        wesd_pkg::CFG_TICKS_PER_MS: cfg.ticks_per_ms    <= cfg_data;
        wesd_pkg::CFG_STEER_THRESH: cfg.steer_threshold <= cfg_data[7:0];
        default: begin
          cfg.step_cm <= cfg.step_cm;
        end
      endcase
    end
  end

  wesd_core #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_req     (s_axis_tuser[2:0]),
    .in_ch      (s_axis_tuser[3]),
    .in_gap     (s_axis_tdata[15:0]),
    .in_cmd     (s_axis_tdata[23:16]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (res)
  );

  // Pack the result word.
  assign m_axis_tdata = {res.dist_two, res.dist_one, res.avg_speed};
  assign m_axis_tuser = {res.dist_ready, res.reached, res.speed_channel, res.speed_ready};

endmodule
